>>> src/iee_pkg.sv
// Package for the infix expression evaluator: token and status codes, widths.
// No dependencies.
package iee_pkg;
  localparam int StackDepthDef = 16;
  localparam int FracBitsDef   = 16;

  typedef enum logic [2:0] {
    TOK_NUM = 3'd0, TOK_LP = 3'd1, TOK_RP = 3'd2, TOK_ADD = 3'd3,
    TOK_SUB = 3'd4, TOK_MUL = 3'd5, TOK_DIV = 3'd6, TOK_END = 3'd7
  } tok_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_DIV0 = 3'd1, ST_NO_LP = 3'd2, ST_NO_RP = 3'd3,
    ST_OVERFLOW = 3'd4, ST_NO_OPERAND = 3'd5
  } status_t;

  // Saturate a 64-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[31:0];
  endfunction
endpackage

>>> src/iee_if.sv
// Valid/ready channel interfaces for the evaluator.
// Depends on iee_pkg.
interface iee_in_if import iee_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [30:0] number_value;
  modport source (output valid, opcode, number_value, input ready);
  modport sink (input valid, opcode, number_value, output ready);
endinterface

interface iee_out_if import iee_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [2:0]         status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

>>> src/iee_ram.sv
// Generic single-port write, single-port read RAM with registered read.
// No dependencies.
module iee_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> src/iee_div.sv
// Iterative signed divider: (a << FracBits) / b, truncated, saturated.
// Depends on iee_pkg.
module iee_div import iee_pkg::*; #(
  parameter int FracBits = FracBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] q
);
  logic [63:0] num;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [31:0] den;
  logic        neg;
  logic        busy;
  logic [5:0]  cnt;
  logic [64:0] trial;
  logic [63:0] qs;
  logic [63:0] mag_a;

  always_comb begin
    trial = {rem[63:0], num[63]} - {33'd0, den};
    mag_a = a[31] ? 64'(-{{32{a[31]}}, a}) : 64'({32'd0, a});
    qs    = neg ? -quo : quo;
  end

  // Restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num  <= mag_a << FracBits;
        den  <= b[31] ? 32'(-b) : 32'(b);
        neg  <= a[31] ^ b[31];
        rem  <= '0;
        quo  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        num <= num << 1;
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], num[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign q = sat32(qs);
endmodule

>>> src/infix_expression_evaluator_core.sv
// Top level of the infix expression evaluator: sequencer around two stack RAMs.
// Depends on iee_pkg, iee_if, iee_ram, iee_div.
//
//   channel  | dir | fields
//   tok      | in  | opcode, number_value
//   res      | out | result_value, status
//
// A number or lparen is pushed at dispatch; any other token reads the operator
// stack top, then pushes, pops or reduces. Each operator applied reads b then a
// and writes the result back, a divide waiting on the bit-serial divider; End
// loads the top operand. Short reductions and lparens left at End are dropped.
// Reset is synchronous and clears counts, the error and the output valid flag;
// the RAMs need no clearing. A full output register holds the block until taken.
module infix_expression_evaluator_core import iee_pkg::*; #(
  parameter int StackDepth = StackDepthDef,
  parameter int FracBits   = FracBitsDef
) (
  input logic      clk,
  input logic      rst,
  iee_in_if.sink   tok,
  iee_out_if.source res
);
  localparam int AW = $clog2(StackDepth);
  localparam int CW = $clog2(StackDepth + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_DISP = 9'b000000010, S_OPRD = 9'b000000100,
    S_OPCK = 9'b000001000, S_ARD  = 9'b000010000, S_BRD  = 9'b000100000,
    S_EXEC = 9'b001000000, S_DIVW = 9'b010000000, S_OUT  = 9'b100000000
  } state_t;

  state_t            state;
  logic [2:0]        op;
  logic [30:0]       val;
  logic [CW-1:0]     nd;
  logic [CW-1:0]     no;
  status_t           err;
  logic [2:0]        top;
  logic signed [31:0] opb;
  logic signed [31:0] opa;

  // Output register
  logic              out_valid;
  logic signed [31:0] out_value;
  status_t           out_status;
  logic              out_load;

  // RAM ports
  logic              d_we, o_we;
  logic [AW-1:0]     d_wa, d_ra, o_wa, o_ra;
  logic [31:0]       d_wd, d_rd;
  logic [2:0]        o_wd, o_rd;

  logic              div_start, div_done;
  logic signed [31:0] div_q;
  logic signed [63:0] prod;
  logic signed [63:0] shp;
  logic signed [31:0] arith;

  iee_ram #(.Width(32), .Depth(StackDepth)) u_dram (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
  iee_ram #(.Width(3), .Depth(StackDepth)) u_oram (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
  iee_div #(.FracBits(FracBits)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .a(opa), .b(opb),
    .done(div_done), .q(div_q));

  // Arithmetic for add, subtract, multiply
  always_comb begin
    prod = 64'(opa) * 64'(opb);
    shp  = prod >>> FracBits;
    case (top)
      TOK_ADD: arith = sat32(64'(opa) + 64'(opb));
      TOK_SUB: arith = sat32(64'(opa) - 64'(opb));
      TOK_MUL: arith = sat32(shp);
      default: arith = '0;
    endcase
  end

  // Read addresses follow the stack tops: b is read first, then a
  assign o_ra = AW'(no - CW'(1));
  assign d_ra = (state == S_ARD) ? AW'(nd - CW'(2)) : AW'(nd - CW'(1));

  assign tok.ready = (state == S_IDLE);
  assign out_load  = (state == S_OUT) && (!out_valid || res.ready);

  always_comb begin
    d_we = 1'b0; d_wa = AW'(nd); d_wd = {1'b0, val};
    o_we = 1'b0; o_wa = AW'(no); o_wd = op;
    div_start = 1'b0;
    if (state == S_DISP && op == TOK_NUM && nd < CW'(StackDepth)) d_we = 1'b1;
    if (state == S_DISP && (op == TOK_LP) && no < CW'(StackDepth)) o_we = 1'b1;
    if (state == S_OPCK && op != TOK_RP && op != TOK_END && !(no != '0 &&
        op <= o_rd) && no < CW'(StackDepth)) o_we = 1'b1;
    if (state == S_EXEC) begin
      d_wa = AW'(nd - CW'(2));
      d_wd = arith;
      if (top == TOK_DIV) div_start = (opb != '0);
      else d_we = 1'b1;
    end
    if (state == S_DIVW && div_done) begin
      d_we = 1'b1; d_wa = AW'(nd - CW'(2)); d_wd = div_q;
    end
    if (state == S_DIVW && opb == '0 && !div_done) begin
      d_we = 1'b1; d_wa = AW'(nd - CW'(2)); d_wd = '0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nd    <= '0;
      no    <= '0;
      err   <= ST_OK;
    end else begin
      case (state)
        S_IDLE: if (tok.valid) begin
          op    <= tok.opcode;
          val   <= tok.number_value;
          state <= S_DISP;
        end
        S_DISP: begin
          case (op)
            TOK_NUM: begin
              if (nd < CW'(StackDepth)) nd <= nd + CW'(1);
              else if (err == ST_OK) err <= ST_OVERFLOW;
              state <= S_IDLE;
            end
            TOK_LP: begin
              if (no < CW'(StackDepth)) no <= no + CW'(1);
              else if (err == ST_OK) err <= ST_OVERFLOW;
              state <= S_IDLE;
            end
            default: state <= S_OPRD;
          endcase
        end
        S_OPRD: state <= S_OPCK;
        S_OPCK: begin
          top <= o_rd;
          if (no == '0) begin
            if (op == TOK_RP) begin
              if (err == ST_OK) err <= ST_NO_LP;
              state <= S_IDLE;
            end else if (op == TOK_END) begin
              // No operator left: read the top operand for the result
              top   <= TOK_END;
              state <= S_ARD;
            end else begin
              if (no < CW'(StackDepth)) no <= no + CW'(1);
              else if (err == ST_OK) err <= ST_OVERFLOW;
              state <= S_IDLE;
            end
          end else if (op == TOK_RP && o_rd == TOK_LP) begin
            no <= no - CW'(1);
            state <= S_IDLE;
          end else if (op == TOK_END && o_rd == TOK_LP) begin
            no <= no - CW'(1);
            if (err == ST_OK) err <= ST_NO_RP;
            state <= S_OPRD;
          end else if (op == TOK_RP || op == TOK_END || op <= o_rd) begin
            no <= no - CW'(1);
            if (nd < CW'(2)) begin
              if (err == ST_OK) err <= ST_NO_OPERAND;
              state <= S_OPRD;
            end else begin
              state <= S_ARD;
            end
          end else begin
            if (no < CW'(StackDepth)) no <= no + CW'(1);
            else if (err == ST_OK) err <= ST_OVERFLOW;
            state <= S_IDLE;
          end
        end
        S_ARD: begin
          // b arrives from the RAM; a is read next
          opb   <= d_rd;
          state <= S_BRD;
        end
        S_BRD: begin
          opa <= d_rd;
          if (top == TOK_ADD || top == TOK_SUB || top == TOK_MUL ||
              top == TOK_DIV) begin
            state <= S_EXEC;
          end else begin
            state <= S_OUT;
          end
        end
        S_EXEC: state <= S_DIVW;
        default: ;
      endcase

      if (state == S_EXEC) begin
        if (top != TOK_DIV) begin
          nd <= nd - CW'(1);
          state <= S_OPRD;
        end else if (opb == '0) begin
          if (err == ST_OK) err <= ST_DIV0;
          state <= S_DIVW;
        end else begin
          state <= S_DIVW;
        end
      end
      if (state == S_DIVW && (div_done || opb == '0)) begin
        nd <= nd - CW'(1);
        state <= S_OPRD;
      end
      if (out_load) begin
        nd <= '0;
        no <= '0;
        err <= ST_OK;
        state <= S_IDLE;
      end
    end
  end

  // Hold the result transaction until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= 1'b1;
      out_value  <= (nd == '0) ? 32'sd0 : opb;
      out_status <= (nd == '0 && err == ST_OK) ? ST_NO_OPERAND : err;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid        = out_valid;
  assign res.result_value = out_value;
  assign res.status       = out_status;
endmodule

>>> test/tb_infix_expression_evaluator_core.sv
// Testbench for infix_expression_evaluator_core: directed and random token streams,
// checked against a shunting-yard predictor. Depends on iee_pkg, iee_if and the core.
module tb_infix_expression_evaluator_core;
  import iee_pkg::*;

  localparam int Depth = StackDepthDef;
  localparam int Frac  = FracBitsDef;
  localparam int CycleLimit = 3000000;

  typedef struct packed {
    logic signed [31:0] value;
    status_t            status;
  } eval_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold_off = 1'b0;
  int   cycle_count = 0;
  int   error_count = 0;
  int   token_count = 0;

  iee_in_if  tok();
  iee_out_if res();

  infix_expression_evaluator_core dut (.clk(clk), .rst(rst), .tok(tok), .res(res));

  always #5 clk = ~clk;

  // Predictor state
  logic signed [31:0] opnd_stk [Depth];
  tok_t               oper_stk [Depth];
  int                 opnd_cnt;
  int                 oper_cnt;
  status_t            first_err;
  eval_result_t       pending_results [$];

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  task automatic record_err(input status_t s);
    if (first_err == ST_OK) first_err = s;
  endtask

  task automatic clear_eval();
    opnd_cnt = 0;
    oper_cnt = 0;
    first_err = ST_OK;
  endtask

  task automatic apply_oper(input tok_t op);
    logic signed [31:0] a, b, r;
    logic signed [63:0] p;
    if (opnd_cnt < 2) begin
      record_err(ST_NO_OPERAND);
      return;
    end
    b = opnd_stk[opnd_cnt-1];
    a = opnd_stk[opnd_cnt-2];
    case (op)
      TOK_ADD: r = clamp32(64'(a) + 64'(b));
      TOK_SUB: r = clamp32(64'(a) - 64'(b));
      TOK_MUL: begin
        p = 64'(a) * 64'(b);
        r = clamp32(p >>> Frac);
      end
      TOK_DIV: begin
        if (b == 0) begin
          record_err(ST_DIV0);
          r = 0;
        end else begin
          p = 64'(a) <<< Frac;
          r = clamp32(p / 64'(b));
        end
      end
      default: r = 0;
    endcase
    opnd_cnt--;
    opnd_stk[opnd_cnt-1] = r;
  endtask

  // Advance the predictor by one token
  task automatic predict_token(input tok_t op, input logic [30:0] num);
    case (op)
      TOK_NUM: begin
        if (opnd_cnt >= Depth) record_err(ST_OVERFLOW);
        else begin
          opnd_stk[opnd_cnt] = {1'b0, num};
          opnd_cnt++;
        end
      end
      TOK_LP: begin
        if (oper_cnt >= Depth) record_err(ST_OVERFLOW);
        else begin
          oper_stk[oper_cnt] = TOK_LP;
          oper_cnt++;
        end
      end
      TOK_RP: begin
        while (oper_cnt > 0 && oper_stk[oper_cnt-1] != TOK_LP) begin
          apply_oper(oper_stk[oper_cnt-1]);
          oper_cnt--;
        end
        if (oper_cnt == 0) record_err(ST_NO_LP);
        else oper_cnt--;
      end
      TOK_END: begin
        eval_result_t er;
        while (oper_cnt > 0) begin
          if (oper_stk[oper_cnt-1] == TOK_LP) record_err(ST_NO_RP);
          else apply_oper(oper_stk[oper_cnt-1]);
          oper_cnt--;
        end
        if (opnd_cnt == 0) begin
          record_err(ST_NO_OPERAND);
          er.value = 0;
        end else begin
          er.value = opnd_stk[opnd_cnt-1];
        end
        er.status = first_err;
        pending_results.push_back(er);
        clear_eval();
      end
      default: begin
        while (oper_cnt > 0 && op <= oper_stk[oper_cnt-1]) begin
          apply_oper(oper_stk[oper_cnt-1]);
          oper_cnt--;
        end
        if (oper_cnt >= Depth) record_err(ST_OVERFLOW);
        else begin
          oper_stk[oper_cnt] = op;
          oper_cnt++;
        end
      end
    endcase
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one token, wait for its transaction, then update the predictor
  task automatic send_token(input tok_t op, input logic [30:0] num);
    tok.valid        <= 1'b1;
    tok.opcode       <= op;
    tok.number_value <= num;
    @(posedge clk);
    while (!tok.ready) @(posedge clk);
    predict_token(op, num);
    token_count++;
    if ($urandom_range(0, 3) == 0) begin
      tok.valid <= 1'b0;
      repeat (1 + gap_len()) @(posedge clk);
    end
  endtask

  task automatic send_idle();
    tok.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [30:0] rand_num();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(0, 3));
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(0, 20)) << Frac;
      3: return 31'($urandom_range(0, 65535));
      default: return 31'($urandom());
    endcase
  endfunction

  // Result checker with random back-pressure
  initial begin
    eval_result_t exp_r;
    res.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (res.valid && res.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result value=%h status=%0d", $time,
                   res.result_value, res.status);
          error_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (res.result_value !== exp_r.value) begin
            $display("%0t: result_value expected %h actual %h", $time,
                     exp_r.value, res.result_value);
            error_count++;
          end
          if (res.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_r.status, res.status);
            error_count++;
          end
        end
      end
      if (hold_off) res.ready <= 1'b0;
      else res.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0 ? 1'b0 : 1'b1)
                        ? ($urandom_range(0, 19) != 0) : 1'b0;
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** infix_expression_evaluator_core: FAILED **");
      $finish;
    end
  end

  task automatic test_simple_ops();
    tok_t ops [4] = '{TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV};
    foreach (ops[i]) begin
      send_token(TOK_NUM, 31'd7 << Frac);
      send_token(ops[i], 0);
      send_token(TOK_NUM, 31'd2 << Frac);
      send_token(TOK_END, 0);
    end
  endtask

  task automatic test_special_cases();
    // divide by zero, saturation on multiply and on subtract
    send_token(TOK_NUM, 31'h7FFF_FFFF); send_token(TOK_DIV, 0);
    send_token(TOK_NUM, 0); send_token(TOK_END, 0);
    send_token(TOK_NUM, 31'h7FFF_FFFF); send_token(TOK_MUL, 0);
    send_token(TOK_NUM, 31'h7FFF_FFFF); send_token(TOK_END, 0);
    send_token(TOK_NUM, 0); send_token(TOK_SUB, 0);
    send_token(TOK_NUM, 31'h7FFF_FFFF); send_token(TOK_SUB, 0);
    send_token(TOK_NUM, 31'h7FFF_FFFF); send_token(TOK_END, 0);
    // unmatched rparen, then unmatched lparen
    send_token(TOK_NUM, 1); send_token(TOK_RP, 0); send_token(TOK_END, 0);
    send_token(TOK_LP, 0); send_token(TOK_NUM, 5); send_token(TOK_END, 0);
    // missing operand and empty expression
    send_token(TOK_ADD, 0); send_token(TOK_END, 0);
    send_token(TOK_END, 0);
    // extra operands
    send_token(TOK_NUM, 3); send_token(TOK_NUM, 4); send_token(TOK_END, 0);
  endtask

  task automatic test_overflow();
    repeat (Depth + 2) send_token(TOK_NUM, rand_num());
    send_token(TOK_END, 0);
    repeat (Depth + 2) send_token(TOK_LP, 0);
    send_token(TOK_END, 0);
  endtask

  // Well-formed expression with random content and nesting
  task automatic send_expression(input int depth_left);
    int terms;
    terms = $urandom_range(1, 4);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) send_token(tok_t'($urandom_range(TOK_ADD, TOK_DIV)), 31'($urandom()));
      if (depth_left > 0 && $urandom_range(0, 3) == 0) begin
        send_token(TOK_LP, 31'($urandom()));
        send_expression(depth_left - 1);
        send_token(TOK_RP, 31'($urandom()));
      end else begin
        send_token(TOK_NUM, rand_num());
      end
    end
  endtask

  // Send random expressions and random token runs until the total token count reaches n_items
  task automatic test_random(input int n_items);
    while (token_count < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        send_expression(2);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_token(tok_t'($urandom_range(0, 6)), 31'($urandom()));
        end
      end
      send_token(TOK_END, 31'($urandom()));
    end
  endtask

  // Receiver holds off while the sender keeps offering tokens
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (12) begin
        send_token(TOK_NUM, rand_num());
        send_token(TOK_ADD, 0);
        send_token(TOK_NUM, rand_num());
        send_token(TOK_END, 0);
      end
    join
  endtask

  initial begin
    tok.valid        = 1'b0;
    tok.opcode       = TOK_NUM;
    tok.number_value = '0;
    clear_eval();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_simple_ops();
    test_special_cases();
    test_overflow();
    test_backpressure();
    test_random(1950);
    send_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) $display("** infix_expression_evaluator_core: PASSED **");
    else $display("** infix_expression_evaluator_core: FAILED **");
    $finish;
  end
endmodule
